// File: src/ptc_pkg.sv
// Shared types, widths, constants and helpers of the pressure/temperature compensation block.
package ptc_pkg;

  // Port and register widths
  localparam int unsigned RawW    = 24;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DegW    = 13;
  localparam int unsigned PaW     = 32;

  // Internal widths, sized from the value ranges of each term
  localparam int unsigned DtW     = 25;  // D2 - C5*256
  localparam int unsigned ProdW   = 42;  // dT times a 16-bit coefficient
  localparam int unsigned SqW     = 48;  // dT squared
  localparam int unsigned Q6W     = 19;  // T1 - 2000
  localparam int unsigned TiW     = 17;
  localparam int unsigned OffW    = 36;
  localparam int unsigned SensW   = 35;
  localparam int unsigned DiffW   = 18;  // |T1 - 2000|
  localparam int unsigned DsqW    = 36;
  localparam int unsigned CsqW    = 34;
  localparam int unsigned TW      = 20;  // second-order temperature, hundredths
  localparam int unsigned TabsW   = 19;
  localparam int unsigned CorrW   = 40;
  localparam int unsigned Off2W   = 41;
  localparam int unsigned Sens2W  = 40;
  localparam int unsigned SensLoW = 20;
  localparam int unsigned RecipW  = 20;
  localparam int unsigned TqW     = TabsW + RecipW;

  // Divide by 100 as multiply by ceil(2^26/100) and shift, exact for |t| < 2^20
  localparam logic [RecipW-1:0] DivRecip = 20'd671089;
  localparam int unsigned       DivShift = 26;

  localparam int TRef        = 2000;
  localparam int VeryLowGap  = 3500;  // 2000 - (-1500)
  localparam int DegMin      = -2300;
  localparam int DegMax      = 1400;
  localparam longint PaMax   = 64'sd2147483647;
  localparam longint PaMin   = -64'sd2147483648;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSensCoeff   = 3'd0,
    CfgOffsetCoeff = 3'd1,
    CfgSensTempco  = 3'd2,
    CfgOffTempco   = 3'd3,
    CfgRefTempRaw  = 3'd4,
    CfgTempSlope   = 3'd5
  } ptc_cfg_idx_e;

  typedef struct packed {
    logic [CoefW-1:0] sens_coeff;
    logic [CoefW-1:0] offset_coeff;
    logic [CoefW-1:0] sens_tempco;
    logic [CoefW-1:0] offset_tempco;
    logic [CoefW-1:0] ref_temp_raw;
    logic [CoefW-1:0] temp_slope;
  } ptc_cfg_t;

  typedef struct packed {
    logic [RawW-1:0]         d1;
    logic signed [Q6W-1:0]   q6;
    logic signed [OffW-1:0]  off;
    logic signed [SensW-1:0] sens;
    logic [TiW-1:0]          ti_lo;
    logic [TiW-1:0]          ti_hi;
  } ptc_first_t;

  typedef struct packed {
    logic [RawW-1:0]          d1;
    logic signed [Off2W-1:0]  off2;
    logic signed [Sens2W-1:0] sens2;
    logic                     tneg;
    logic [TqW-1:0]           tq;
  } ptc_second_t;

  // Signed divide by 2^k, truncating toward zero
  function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
                                                  input int unsigned k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage

// File: src/pressure_temperature_compensation.sv
// Top level: calibration registers and the twelve-stage compensation pipeline.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i (3b), cfg_data_i (16b)
//   in       | in_valid_i / in_ready_o   | pressure_raw_i (24b), temperature_raw_i (24b)
//   out      | out_valid_o / out_ready_i | temperature_deg_o (13b s), pressure_pa_o (32b s)
//
// One request enters per cycle while in_ready_o is high. Its result reaches the output register
// through the twelve register stages (front 3, second-order 3, output 6).
// Reset clears the six calibration words to zero and empties every stage.
// A stall on the output holds only the stages that are full; bubbles upstream keep closing,
// so in_ready_o stays high as long as any stage can still take a request.
// Configuration writes are always accepted and take effect at the next edge.
module pressure_temperature_compensation (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Calibration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ptc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ptc_pkg::CoefW-1:0]       cfg_data_i,
  // Raw reading requests
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ptc_pkg::RawW-1:0]        pressure_raw_i,
  input  logic [ptc_pkg::RawW-1:0]        temperature_raw_i,
  // Compensated results
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [ptc_pkg::DegW-1:0] temperature_deg_o,
  output logic signed [ptc_pkg::PaW-1:0]  pressure_pa_o
);

  // Calibration words: the user must write them only while the pipeline is drained (the
  // block does not enforce this), so the stages read them directly without a per-request copy.
  ptc_pkg::ptc_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ptc_pkg::ptc_cfg_idx_e'(cfg_index_i))
        ptc_pkg::CfgSensCoeff:   cfg_q.sens_coeff    <= cfg_data_i;
        ptc_pkg::CfgOffsetCoeff: cfg_q.offset_coeff  <= cfg_data_i;
        ptc_pkg::CfgSensTempco:  cfg_q.sens_tempco   <= cfg_data_i;
        ptc_pkg::CfgOffTempco:   cfg_q.offset_tempco <= cfg_data_i;
        ptc_pkg::CfgRefTempRaw:  cfg_q.ref_temp_raw  <= cfg_data_i;
        ptc_pkg::CfgTempSlope:   cfg_q.temp_slope    <= cfg_data_i;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // First order: dT, coefficient products, T1, OFF, SENS
  logic                 first_valid, first_ready;
  ptc_pkg::ptc_first_t  first;

  ptc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .pressure_raw_i    (pressure_raw_i),
    .temperature_raw_i (temperature_raw_i),
    .out_valid_o       (first_valid),
    .out_ready_i       (first_ready),
    .out_o             (first)
  );

  // Second order: branch, corrections, corrected OFF and SENS
  logic                 second_valid, second_ready;
  ptc_pkg::ptc_second_t second;

  ptc_second u_second (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (first_valid),
    .in_ready_o  (first_ready),
    .in_i        (first),
    .out_valid_o (second_valid),
    .out_ready_i (second_ready),
    .out_o       (second)
  );

  // Pressure product and scaling, temperature in degrees, output register
  ptc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (second_valid),
    .in_ready_o        (second_ready),
    .in_i              (second),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .temperature_deg_o (temperature_deg_o),
    .pressure_pa_o     (pressure_pa_o)
  );

  // An empty output stage frees every stage behind it, so the input must be open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked while output stage is empty");

  // A stalled result must not block a pipeline that still has room at the front
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_valid && !second_valid |-> in_ready_o)
    else $error("input blocked with empty inner stages");

endmodule

// File: src/ptc_front.sv
// First-order stages: temperature difference, coefficient products, T1, OFF and SENS.
module ptc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ptc_pkg::ptc_cfg_t     cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ptc_pkg::RawW-1:0] pressure_raw_i,
  input  logic [ptc_pkg::RawW-1:0] temperature_raw_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ptc_pkg::ptc_first_t   out_o
);

  localparam int unsigned NumStages = 3;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NumStages; s++) begin
        if (adv[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // Stage 1: dT
  logic [ptc_pkg::RawW-1:0]       d1_s1_q;
  logic signed [ptc_pkg::DtW-1:0] dt_d, dt_q;

  assign dt_d = $signed({1'b0, temperature_raw_i}) - $signed({1'b0, cfg_i.ref_temp_raw, 8'b0});

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      d1_s1_q <= pressure_raw_i;
      dt_q    <= dt_d;
    end
  end

  // Stage 2: products of dT
  logic [ptc_pkg::RawW-1:0]         d1_s2_q;
  logic signed [ptc_pkg::ProdW-1:0] p6_d, p4_d, p3_d, p6_q, p4_q, p3_q;
  logic signed [2*ptc_pkg::DtW-1:0] sq_full;
  logic [ptc_pkg::SqW-1:0]          sq_q;

  assign p6_d    = dt_q * $signed({1'b0, cfg_i.temp_slope});
  assign p4_d    = dt_q * $signed({1'b0, cfg_i.offset_tempco});
  assign p3_d    = dt_q * $signed({1'b0, cfg_i.sens_tempco});
  assign sq_full = dt_q * dt_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      d1_s2_q <= d1_s1_q;
      p6_q    <= p6_d;
      p4_q    <= p4_d;
      p3_q    <= p3_d;
      sq_q    <= sq_full[ptc_pkg::SqW-1:0];
    end
  end

  // Stage 3: scale back, add the reference terms, both Ti candidates
  ptc_pkg::ptc_first_t     s3_d, s3_q;
  logic [ptc_pkg::SqW+2:0] sq3;
  logic [ptc_pkg::SqW+3:0] sq7;

  always_comb begin
    sq3 = (ptc_pkg::SqW+3)'(sq_q) + (ptc_pkg::SqW+3)'({sq_q, 1'b0});
    sq7 = (ptc_pkg::SqW+4)'({sq_q, 3'b0}) - (ptc_pkg::SqW+4)'(sq_q);
    s3_d.d1    = d1_s2_q;
    s3_d.q6    = ptc_pkg::Q6W'(ptc_pkg::sdiv_pow2(64'(p6_q), 23));
    s3_d.off   = ptc_pkg::OffW'($signed({1'b0, cfg_i.offset_coeff, 16'b0}))
               + ptc_pkg::OffW'(ptc_pkg::sdiv_pow2(64'(p4_q), 7));
    s3_d.sens  = ptc_pkg::SensW'($signed({1'b0, cfg_i.sens_coeff, 15'b0}))
               + ptc_pkg::SensW'(ptc_pkg::sdiv_pow2(64'(p3_q), 8));
    s3_d.ti_lo = ptc_pkg::TiW'(sq3 >> 33);
    s3_d.ti_hi = ptc_pkg::TiW'(sq7 >> 37);
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_q <= s3_d;
    end
  end

  assign out_o = s3_q;

endmodule

// File: src/ptc_second.sv
// Second-order stages: branch selection, correction terms, corrected OFF/SENS and T scaling.
module ptc_second (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ptc_pkg::ptc_first_t  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ptc_pkg::ptc_second_t out_o
);

  localparam int unsigned NumStages = 3;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NumStages; s++) begin
        if (adv[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // Stage 4: branch flags, squares, second-order temperature
  logic                            lowbr_d, vlow_d, lowbr_s4_q, vlow_s4_q;
  logic signed [ptc_pkg::Q6W-1:0]  q6_neg, cval;
  logic [ptc_pkg::DiffW-1:0]       diff;
  logic [ptc_pkg::DsqW-1:0]        dsq_d, dsq_q;
  logic signed [2*ptc_pkg::Q6W-1:0] csq_full;
  logic [ptc_pkg::CsqW-1:0]        csq_q;
  logic [ptc_pkg::TiW-1:0]         ti_sel;
  logic signed [ptc_pkg::TW-1:0]   t_d, t_q;
  logic [ptc_pkg::RawW-1:0]        d1_s4_q;
  logic signed [ptc_pkg::OffW-1:0] off_s4_q;
  logic signed [ptc_pkg::SensW-1:0] sens_s4_q;

  always_comb begin
    lowbr_d  = in_i.q6[ptc_pkg::Q6W-1];
    vlow_d   = $signed(in_i.q6) < -ptc_pkg::VeryLowGap;
    q6_neg   = -in_i.q6;
    diff     = lowbr_d ? q6_neg[ptc_pkg::DiffW-1:0] : in_i.q6[ptc_pkg::DiffW-1:0];
    cval     = in_i.q6 + ptc_pkg::Q6W'(ptc_pkg::VeryLowGap);
    dsq_d    = diff * diff;
    csq_full = cval * cval;
    ti_sel   = lowbr_d ? in_i.ti_lo : in_i.ti_hi;
    t_d      = ptc_pkg::TW'(in_i.q6) + ptc_pkg::TW'(ptc_pkg::TRef)
             - ptc_pkg::TW'({1'b0, ti_sel});
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      lowbr_s4_q <= lowbr_d;
      vlow_s4_q  <= vlow_d;
      dsq_q      <= dsq_d;
      csq_q      <= csq_full[ptc_pkg::CsqW-1:0];
      t_q        <= t_d;
      d1_s4_q    <= in_i.d1;
      off_s4_q   <= in_i.off;
      sens_s4_q  <= in_i.sens;
    end
  end

  // Stage 5: correction terms and |T|
  logic [ptc_pkg::DsqW+1:0]         dsq3, dsq5;
  logic [ptc_pkg::CsqW+2:0]         csq7;
  logic [ptc_pkg::CorrW-1:0]        offi_d, sensi_d, offi_q, sensi_q;
  logic signed [ptc_pkg::TW-1:0]    t_neg;
  logic                             tneg_d, tneg_q, lowbr_s5_q;
  logic [ptc_pkg::TabsW-1:0]        tabs_d, tabs_q;
  logic [ptc_pkg::RawW-1:0]         d1_s5_q;
  logic signed [ptc_pkg::OffW-1:0]  off_s5_q;
  logic signed [ptc_pkg::SensW-1:0] sens_s5_q;

  always_comb begin
    dsq3 = (ptc_pkg::DsqW+2)'(dsq_q) + (ptc_pkg::DsqW+2)'({dsq_q, 1'b0});
    dsq5 = (ptc_pkg::DsqW+2)'(dsq_q) + (ptc_pkg::DsqW+2)'({dsq_q, 2'b0});
    csq7 = (ptc_pkg::CsqW+3)'({csq_q, 3'b0}) - (ptc_pkg::CsqW+3)'(csq_q);
    if (lowbr_s4_q) begin
      offi_d  = ptc_pkg::CorrW'(dsq3 >> 1)
              + (vlow_s4_q ? ptc_pkg::CorrW'(csq7) : '0);
      sensi_d = ptc_pkg::CorrW'(dsq5 >> 3)
              + (vlow_s4_q ? ptc_pkg::CorrW'({csq_q, 2'b0}) : '0);
    end else begin
      offi_d  = ptc_pkg::CorrW'(dsq_q >> 4);
      sensi_d = '0;
    end
    t_neg  = -t_q;
    tneg_d = t_q[ptc_pkg::TW-1];
    tabs_d = tneg_d ? t_neg[ptc_pkg::TabsW-1:0] : t_q[ptc_pkg::TabsW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      offi_q     <= offi_d;
      sensi_q    <= sensi_d;
      tneg_q     <= tneg_d;
      tabs_q     <= tabs_d;
      lowbr_s5_q <= lowbr_s4_q;
      d1_s5_q    <= d1_s4_q;
      off_s5_q   <= off_s4_q;
      sens_s5_q  <= sens_s4_q;
    end
  end

  // Stage 6: apply corrections, start the divide by 100
  ptc_pkg::ptc_second_t s6_d, s6_q;

  always_comb begin
    s6_d.d1    = d1_s5_q;
    s6_d.off2  = ptc_pkg::Off2W'(off_s5_q) - ptc_pkg::Off2W'(offi_q);
    s6_d.sens2 = ptc_pkg::Sens2W'(sens_s5_q) - ptc_pkg::Sens2W'(sensi_q);
    s6_d.tneg  = tneg_q;
    s6_d.tq    = tabs_q * ptc_pkg::DivRecip;
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s6_q <= s6_d;
    end
  end

  assign out_o = s6_q;

  // The very-low-temperature branch is a sub-case of the low one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && vlow_s4_q |-> lowbr_s4_q)
    else $error("very-low flag without low-temperature flag");

  // The high-temperature branch carries no sensitivity correction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && !lowbr_s5_q |-> sensi_q == '0)
    else $error("sensitivity correction in high-temperature branch");

endmodule

// File: src/ptc_back.sv
// Output stages: D1*SENS in two partial products, pressure scaling, temperature in degrees.
module ptc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ptc_pkg::ptc_second_t          in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ptc_pkg::DegW-1:0] temperature_deg_o,
  output logic signed [ptc_pkg::PaW-1:0]  pressure_pa_o
);

  localparam int unsigned NumStages = 6;
  localparam int unsigned PlW  = ptc_pkg::RawW + ptc_pkg::SensLoW;
  localparam int unsigned PhW  = ptc_pkg::RawW + 1 + ptc_pkg::Sens2W - ptc_pkg::SensLoW;
  localparam int unsigned A1W  = 43;
  localparam int unsigned AW   = 44;
  localparam int unsigned PW   = 29;
  localparam int unsigned P10W = PW + 4;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NumStages; s++) begin
        if (adv[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // Stage 7: partial products, temperature quotient and sign
  logic [PlW-1:0]                     pl_d, pl_q;
  logic signed [PhW-1:0]              ph_d, ph_q;
  logic [ptc_pkg::DegW-1:0]           tmag;
  logic signed [ptc_pkg::DegW:0]      deg14_d, deg14_q;
  logic signed [ptc_pkg::Off2W-1:0]   off2_s7_q;

  always_comb begin
    pl_d    = in_i.d1 * in_i.sens2[ptc_pkg::SensLoW-1:0];
    ph_d    = $signed({1'b0, in_i.d1}) * $signed(in_i.sens2[ptc_pkg::Sens2W-1:ptc_pkg::SensLoW]);
    tmag    = ptc_pkg::DegW'(in_i.tq >> ptc_pkg::DivShift);
    deg14_d = in_i.tneg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      pl_q      <= pl_d;
      ph_q      <= ph_d;
      deg14_q   <= deg14_d;
      off2_s7_q <= in_i.off2;
    end
  end

  // Stage 8: combine the product, clamp the temperature
  logic signed [63:0]               prod_d, prod_q;
  logic signed [ptc_pkg::DegW-1:0]  deg_d, deg_s8_q;
  logic signed [ptc_pkg::Off2W-1:0] off2_s8_q;

  always_comb begin
    prod_d = (64'(ph_q) <<< ptc_pkg::SensLoW) + 64'(pl_q);
    if (deg14_q < ptc_pkg::DegMin) begin
      deg_d = ptc_pkg::DegW'(ptc_pkg::DegMin);
    end else if (deg14_q > ptc_pkg::DegMax) begin
      deg_d = ptc_pkg::DegW'(ptc_pkg::DegMax);
    end else begin
      deg_d = deg14_q[ptc_pkg::DegW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      prod_q    <= prod_d;
      deg_s8_q  <= deg_d;
      off2_s8_q <= off2_s7_q;
    end
  end

  // Stage 9: D1*SENS / 2^21
  logic signed [A1W-1:0]            a1_q;
  logic signed [ptc_pkg::DegW-1:0]  deg_s9_q;
  logic signed [ptc_pkg::Off2W-1:0] off2_s9_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      a1_q      <= A1W'(ptc_pkg::sdiv_pow2(prod_q, 21));
      deg_s9_q  <= deg_s8_q;
      off2_s9_q <= off2_s8_q;
    end
  end

  // Stage 10: subtract the offset
  logic signed [AW-1:0]            a_q;
  logic signed [ptc_pkg::DegW-1:0] deg_s10_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      a_q       <= AW'(a1_q) - AW'(off2_s9_q);
      deg_s10_q <= deg_s9_q;
    end
  end

  // Stage 11: / 2^15, tenths of a millibar
  logic signed [PW-1:0]            p_q;
  logic signed [ptc_pkg::DegW-1:0] deg_s11_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      p_q       <= PW'(ptc_pkg::sdiv_pow2(64'(a_q), 15));
      deg_s11_q <= deg_s10_q;
    end
  end

  // Stage 12: times ten, saturate; this is the output register
  logic signed [P10W-1:0]         p10;
  logic signed [ptc_pkg::PaW-1:0] pa_d, pa_q;
  logic signed [ptc_pkg::DegW-1:0] deg_q;

  always_comb begin
    p10 = (P10W'(p_q) <<< 3) + (P10W'(p_q) <<< 1);
    if (p10 > ptc_pkg::PaMax) begin
      pa_d = ptc_pkg::PaW'(ptc_pkg::PaMax);
    end else if (p10 < ptc_pkg::PaMin) begin
      pa_d = ptc_pkg::PaW'(ptc_pkg::PaMin);
    end else begin
      pa_d = p10[ptc_pkg::PaW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      pa_q  <= pa_d;
      deg_q <= deg_s11_q;
    end
  end

  assign temperature_deg_o = deg_q;
  assign pressure_pa_o     = pa_q;

  // Clamped temperature stays in its range once it enters the pressure path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (deg_s8_q >= ptc_pkg::DegMin) && (deg_s8_q <= ptc_pkg::DegMax))
    else $error("clamped temperature out of range");

endmodule

// File: dv/ptc_compensation_check.sv
// Checker for the compensation block: watches all channels, predicts each result and compares it.
`timescale 1ns / 100ps

module ptc_compensation_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [ptc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ptc_pkg::CoefW-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [ptc_pkg::RawW-1:0]         pressure_raw_i,
  input  logic [ptc_pkg::RawW-1:0]         temperature_raw_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [ptc_pkg::DegW-1:0]  temperature_deg_i,
  input  logic signed [ptc_pkg::PaW-1:0]   pressure_pa_i,
  output int unsigned                      pending_o,
  output int unsigned                      fail_count_o
);

  localparam longint Pow7   = 64'sd1 <<< 7;
  localparam longint Pow8   = 64'sd1 <<< 8;
  localparam longint Pow15  = 64'sd1 <<< 15;
  localparam longint Pow16  = 64'sd1 <<< 16;
  localparam longint Pow21  = 64'sd1 <<< 21;
  localparam longint Pow23  = 64'sd1 <<< 23;
  localparam longint Pow33  = 64'sd1 <<< 33;
  localparam longint Pow37  = 64'sd1 <<< 37;
  localparam longint KneeT  = ptc_pkg::TRef - ptc_pkg::VeryLowGap;

  typedef struct {
    logic [ptc_pkg::RawW-1:0]        p_raw;
    logic [ptc_pkg::RawW-1:0]        t_raw;
    logic signed [ptc_pkg::DegW-1:0] deg;
    logic signed [ptc_pkg::PaW-1:0]  pa;
  } comp_result_t;

  ptc_pkg::ptc_cfg_t cal;
  comp_result_t      compensated_q[$];
  int unsigned       mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("%0t ns  MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  // First-order terms, second-order correction, then pressure from the corrected terms.
  // All products in signed 64 bits; SystemVerilog division truncates toward zero.
  function automatic comp_result_t compensate(input ptc_pkg::ptc_cfg_t c,
                                              input logic [ptc_pkg::RawW-1:0] p_raw,
                                              input logic [ptc_pkg::RawW-1:0] t_raw);
    longint d1, dt, t1, off, sens, ti, off_corr, sens_corr, dev, knee, t_c, p, deg, pa;
    comp_result_t r;
    d1   = longint'({40'd0, p_raw});
    dt   = longint'({40'd0, t_raw}) - longint'({48'd0, c.ref_temp_raw}) * 256;
    t1   = ptc_pkg::TRef + dt * longint'({48'd0, c.temp_slope}) / Pow23;
    off  = longint'({48'd0, c.offset_coeff}) * Pow16
         + longint'({48'd0, c.offset_tempco}) * dt / Pow7;
    sens = longint'({48'd0, c.sens_coeff}) * Pow15
         + longint'({48'd0, c.sens_tempco}) * dt / Pow8;
    if (t1 < ptc_pkg::TRef) begin
      dev       = ptc_pkg::TRef - t1;
      ti        = 3 * dt * dt / Pow33;
      off_corr  = 3 * dev * dev / 2;
      sens_corr = 5 * dev * dev / 8;
      if (t1 < KneeT) begin
        knee      = t1 - KneeT;
        off_corr  = off_corr + 7 * knee * knee;
        sens_corr = sens_corr + 4 * knee * knee;
      end
    end else begin
      dev       = t1 - ptc_pkg::TRef;
      ti        = 7 * dt * dt / Pow37;
      off_corr  = dev * dev / 16;
      sens_corr = 0;
    end
    t_c  = t1 - ti;
    off  = off - off_corr;
    sens = sens - sens_corr;
    p    = (d1 * sens / Pow21 - off) / Pow15;
    deg  = t_c / 100;
    if (deg < ptc_pkg::DegMin) deg = ptc_pkg::DegMin;
    if (deg > ptc_pkg::DegMax) deg = ptc_pkg::DegMax;
    pa = p * 10;
    if (pa < ptc_pkg::PaMin) pa = ptc_pkg::PaMin;
    if (pa > ptc_pkg::PaMax) pa = ptc_pkg::PaMax;
    r.p_raw = p_raw;
    r.t_raw = t_raw;
    r.deg   = deg[ptc_pkg::DegW-1:0];
    r.pa    = pa[ptc_pkg::PaW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    comp_result_t want;
    if (!rst_ni) begin
      cal = '0;
      compensated_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ptc_pkg::CfgSensCoeff:   cal.sens_coeff    = cfg_data_i;
          ptc_pkg::CfgOffsetCoeff: cal.offset_coeff  = cfg_data_i;
          ptc_pkg::CfgSensTempco:  cal.sens_tempco   = cfg_data_i;
          ptc_pkg::CfgOffTempco:   cal.offset_tempco = cfg_data_i;
          ptc_pkg::CfgRefTempRaw:  cal.ref_temp_raw  = cfg_data_i;
          ptc_pkg::CfgTempSlope:   cal.temp_slope    = cfg_data_i;
          default: ;  // spare indexes change nothing
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        compensated_q.push_back(compensate(cal, pressure_raw_i, temperature_raw_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (compensated_q.size() == 0) begin
          report_mismatch($sformatf("result deg %0d pa %0d with no request pending",
                                    temperature_deg_i, pressure_pa_i));
        end else begin
          want = compensated_q.pop_front();
          if (temperature_deg_i !== want.deg) begin
            report_mismatch($sformatf("temperature_deg for p_raw %0d t_raw %0d: got %0d, want %0d",
                                      want.p_raw, want.t_raw, temperature_deg_i, want.deg));
          end
          if (pressure_pa_i !== want.pa) begin
            report_mismatch($sformatf("pressure_pa for p_raw %0d t_raw %0d: got %0d, want %0d",
                                      want.p_raw, want.t_raw, pressure_pa_i, want.pa));
          end
        end
      end
      pending_o <= compensated_q.size();
    end
  end

endmodule

// File: dv/tb.sv
// Testbench top: drives calibration writes and reading requests into the block, gives the verdict.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned HalfPeriod  = 5;
  localparam int unsigned ResetCycles = 2;
  localparam int unsigned MaxGap      = 9;
  localparam int unsigned RandPhases  = 10;
  localparam int unsigned PhaseItems  = 165;
  localparam int unsigned DrainCycles = 24;    // sized from the twelve-stage pipeline depth
  localparam int unsigned IdleLimit   = 2000;  // cycles with no request moving on any channel
  localparam logic [ptc_pkg::RawW-1:0]  RawMax  = '1;
  localparam logic [ptc_pkg::CoefW-1:0] CoefMax = '1;
  localparam longint                    RawTop  = (64'sd1 <<< ptc_pkg::RawW) - 1;
  localparam longint                    Pow23   = 64'sd1 <<< 23;
  // Register indexes past the six calibration words; writes there must be dropped
  localparam logic [ptc_pkg::CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [ptc_pkg::CfgIdxW-1:0] CfgSpareHi = 3'd7;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [ptc_pkg::CfgIdxW-1:0]      cfg_index_i;
  logic [ptc_pkg::CoefW-1:0]        cfg_data_i;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic [ptc_pkg::RawW-1:0]         pressure_raw_i;
  logic [ptc_pkg::RawW-1:0]         temperature_raw_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic signed [ptc_pkg::DegW-1:0]  temperature_deg_o;
  logic signed [ptc_pkg::PaW-1:0]   pressure_pa_o;

  int unsigned       fail_count;
  int unsigned       pending;
  bit                no_idle;   // changed only between phases, while both channels are quiet
  ptc_pkg::ptc_cfg_t cal_set;   // calibration currently held by the block

  always #HalfPeriod clk_i = ~clk_i;

  pressure_temperature_compensation dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .pressure_raw_i    (pressure_raw_i),
    .temperature_raw_i (temperature_raw_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .temperature_deg_o (temperature_deg_o),
    .pressure_pa_o     (pressure_pa_o)
  );

  ptc_compensation_check u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .pressure_raw_i    (pressure_raw_i),
    .temperature_raw_i (temperature_raw_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .temperature_deg_i (temperature_deg_o),
    .pressure_pa_i     (pressure_pa_o),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  // Hold one calibration write until the block takes it; the caller drops valid afterwards.
  task automatic write_reg(input logic [ptc_pkg::CfgIdxW-1:0] idx,
                           input logic [ptc_pkg::CoefW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Write all six words, framed by writes to the spare indexes, which must change nothing.
  task automatic program_cal(input ptc_pkg::ptc_cfg_t c);
    write_reg(CfgSpareLo, ptc_pkg::CoefW'($urandom_range(0, CoefMax)));
    write_reg(ptc_pkg::CfgSensCoeff, c.sens_coeff);
    write_reg(ptc_pkg::CfgOffsetCoeff, c.offset_coeff);
    write_reg(ptc_pkg::CfgSensTempco, c.sens_tempco);
    write_reg(ptc_pkg::CfgOffTempco, c.offset_tempco);
    write_reg(ptc_pkg::CfgRefTempRaw, c.ref_temp_raw);
    write_reg(ptc_pkg::CfgTempSlope, c.temp_slope);
    write_reg(CfgSpareHi, ptc_pkg::CoefW'($urandom_range(0, CoefMax)));
    cfg_valid_i <= 1'b0;
    cal_set = c;
  endtask

  // Present one reading request after a random gap, or none while no_idle is set, and hold it until accepted.
  // Valid is assigned once per time step: low for a gap, or straight back high.
  task automatic send_reading(input logic [ptc_pkg::RawW-1:0] p_raw,
                              input logic [ptc_pkg::RawW-1:0] t_raw);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxGap);
    pressure_raw_i    <= p_raw;
    temperature_raw_i <= t_raw;
    in_valid_i        <= (gap == 0);
    if (gap != 0) begin
      repeat (gap) @(posedge clk_i);
      in_valid_i <= 1'b1;
    end
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every result has come back. Move on to the next edge first so the
  // count from the checker already includes the last accepted request.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Raw temperature that puts the first-order temperature at 20.00 C minus drop hundredths,
  // for the calibration in the block. Clip to the 24-bit range.
  function automatic logic [ptc_pkg::RawW-1:0] temp_raw_at(input int drop);
    longint slope, mag, span, raw;
    slope = longint'({48'd0, cal_set.temp_slope});
    span  = 0;
    if (slope != 0) begin
      mag  = (drop < 0) ? -drop : drop;
      span = (mag * Pow23 + slope - 1) / slope;
      if (drop < 0) span = -span;
    end
    raw = longint'({48'd0, cal_set.ref_temp_raw}) * 256 - span;
    if (raw < 0) raw = 0;
    if (raw > RawTop) raw = RawTop;
    return raw[ptc_pkg::RawW-1:0];
  endfunction

  // Aim a quarter of the temperatures at each branch edge, a quarter across the branches,
  // the rest anywhere in the 24-bit range.
  function automatic logic [ptc_pkg::RawW-1:0] pick_temp_raw();
    case ($urandom_range(0, 3))
      0:       return temp_raw_at(int'($urandom_range(0, 10)) - 5);
      1:       return temp_raw_at(ptc_pkg::VeryLowGap + int'($urandom_range(0, 10)) - 5);
      2:       return temp_raw_at(int'($urandom_range(0, 8000)) - 3000);
      default: return ptc_pkg::RawW'($urandom_range(0, RawMax));
    endcase
  endfunction

  function automatic logic [ptc_pkg::RawW-1:0] pick_pressure_raw();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return RawMax;
      default: return ptc_pkg::RawW'($urandom_range(0, RawMax));
    endcase
  endfunction

  function automatic logic [ptc_pkg::CoefW-1:0] pick_cal_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return CoefMax;
      default: return ptc_pkg::CoefW'($urandom_range(0, CoefMax));
    endcase
  endfunction

  // Result side: per result, stall a random gap (none while no_idle is set), then hold ready until it moves.
  initial begin : drain_side
    int unsigned stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MaxGap);
      out_ready_i <= (stall == 0);
      if (stall != 0) begin
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // End the run when no request has moved on any channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t ns  timeout with %0d results outstanding", $time, pending);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    ptc_pkg::ptc_cfg_t cal;
    cfg_valid_i       <= 1'b0;
    cfg_index_i       <= ptc_pkg::CfgSensCoeff;
    cfg_data_i        <= '0;
    in_valid_i        <= 1'b0;
    pressure_raw_i    <= '0;
    temperature_raw_i <= '0;
    no_idle = 1'b0;
    cal_set = '0;
    rst_ni <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Uncalibrated block: all six words still at zero, computed like any other values
    send_reading('0, '0);
    send_reading(RawMax, RawMax);
    send_reading(RawMax, '0);
    send_reading(24'd4311550, 24'd8387300);
    wait_drained();

    // Typical factory calibration; walk the branch edges of the second-order correction
    cal = '{sens_coeff: 16'd46372, offset_coeff: 16'd43981, sens_tempco: 16'd29059,
            offset_tempco: 16'd27842, ref_temp_raw: 16'd31553, temp_slope: 16'd28165};
    program_cal(cal);
    send_reading(24'd4311550, 24'd8387300);
    send_reading(24'd4311550, temp_raw_at(0));                  // exactly 20.00 C, warm branch
    send_reading(24'd4311550, temp_raw_at(1));                  // just under 20.00 C, cold branch
    send_reading(24'd4311550, temp_raw_at(-1));                 // just over 20.00 C
    send_reading(RawMax, temp_raw_at(ptc_pkg::VeryLowGap));     // exactly -15.00 C, no extra term
    send_reading('0, temp_raw_at(ptc_pkg::VeryLowGap + 1));     // just under -15.00 C
    send_reading(RawMax, '0);
    send_reading('0, RawMax);
    wait_drained();

    // Every word at its maximum: largest products and the coldest reachable temperature
    program_cal('1);
    send_reading('0, '0);
    send_reading(RawMax, RawMax);
    send_reading(RawMax, '0);
    send_reading('0, RawMax);
    send_reading(RawMax, temp_raw_at(ptc_pkg::VeryLowGap + 1));
    wait_drained();

    // Random phases: fresh calibration each time, one all-ones and one all-zero among them
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        1: cal = '1;
        2: cal = '0;
        default: begin
          cal.sens_coeff    = pick_cal_word();
          cal.offset_coeff  = pick_cal_word();
          cal.sens_tempco   = pick_cal_word();
          cal.offset_tempco = pick_cal_word();
          cal.ref_temp_raw  = pick_cal_word();
          cal.temp_slope    = pick_cal_word();
        end
      endcase
      // Run some phases back to back with no gaps and no stalls
      no_idle = (ph % 4 == 3) || ($urandom_range(0, 4) == 0);
      program_cal(cal);
      repeat (PhaseItems) send_reading(pick_pressure_raw(), pick_temp_raw());
      wait_drained();
    end

    // Give a stray extra result time to show up
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
